### rtl/bounded_lifo_stack_defines.svh
// assertion macros used by the checker file
`ifndef BOUNDED_LIFO_STACK_DEFINES_SVH
`define BOUNDED_LIFO_STACK_DEFINES_SVH

// property checked while out of reset
`define BLS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define BLS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bls_pkg.sv
package bls_pkg;

  // fixed field widths
  localparam int WORD_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // default number of stored words
  localparam int DEPTH_DEFAULT = 16;

  // command codes
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH    = 3'd0,
    KIND_POP     = 3'd1,
    KIND_PEEK    = 3'd2,
    KIND_DUMP    = 3'd3,
    KIND_REVERSE = 3'd4,
    KIND_CLEAR   = 3'd5
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DUMP,
    S_REV_WR_LO,
    S_REV_WR_HI,
    S_DONE
  } state_t;

  // memory strobes from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

endpackage

### rtl/bls_cmd_if.sv
interface bls_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [bls_pkg::KIND_W-1:0] kind;
  logic [bls_pkg::WORD_W-1:0] push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink (input valid, input kind, input push_value, output ready);
endinterface

### rtl/bls_res_if.sv
interface bls_res_if;
  logic                         valid;
  logic                         ready;
  logic [bls_pkg::WORD_W-1:0]   value;
  logic [bls_pkg::STATUS_W-1:0] status;
  logic [bls_pkg::COUNT_W-1:0]  count;
  logic                         is_empty;
  logic                         is_full;
  logic                         last;

  modport source (output valid, output value, output status, output count,
                  output is_empty, output is_full, output last, input ready);
  modport sink (input valid, input value, input status, input count,
                input is_empty, input is_full, input last, output ready);
endinterface

### rtl/bls_ram.sv
module bls_ram #(
  parameter int DEPTH = bls_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  bls_pkg::ram_ctl_t          ctl,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [bls_pkg::WORD_W-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr_a,
  input  logic [$clog2(DEPTH)-1:0]   raddr_b,
  output logic [bls_pkg::WORD_W-1:0] rdata_a,
  output logic [bls_pkg::WORD_W-1:0] rdata_b
);

  logic [bls_pkg::WORD_W-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // two registered read ports, data held while no read is issued
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### rtl/bls_ctrl.sv
module bls_ctrl #(
  parameter int DEPTH = bls_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  bls_cmd_if.sink                    cmd,
  bls_res_if.source                  res,
  output bls_pkg::ram_ctl_t          ram_ctl,
  output logic [$clog2(DEPTH)-1:0]   waddr,
  output logic [bls_pkg::WORD_W-1:0] wdata,
  output logic [$clog2(DEPTH)-1:0]   raddr_a,
  output logic [$clog2(DEPTH)-1:0]   raddr_b,
  input  logic [bls_pkg::WORD_W-1:0] rdata_a,
  input  logic [bls_pkg::WORD_W-1:0] rdata_b
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int AW1    = ADDR_W + 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  bls_pkg::state_t state, state_next;

  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [ADDR_W-1:0] lo, lo_next;
  logic [ADDR_W-1:0] hi, hi_next;
  logic              is_pop;

  // output register
  logic                       out_valid;
  logic [bls_pkg::WORD_W-1:0] out_value;
  bls_pkg::status_t           out_status;
  logic [CNT_W-1:0]           out_cnt;
  logic                       out_last;

  // result being loaded this cycle
  logic                       emit;
  logic [bls_pkg::WORD_W-1:0] e_value;
  bls_pkg::status_t           e_status;
  logic                       e_last;

  logic              out_free;
  logic              in_ready;
  logic              accept;
  logic              empty;
  logic              full;
  logic [ADDR_W-1:0] top_addr;
  logic              dump_last;
  logic              rev_more;
  bls_pkg::kind_t    kind;

  // shared conditions
  assign out_free  = !out_valid || res.ready;
  assign accept    = cmd.valid && in_ready;
  assign kind      = bls_pkg::kind_t'(cmd.kind);
  assign empty     = (cnt == '0);
  assign full      = (cnt == CNT_W'(DEPTH));
  assign top_addr  = ADDR_W'(cnt - CNT_W'(1));
  assign dump_last = (lo == top_addr);
  assign rev_more  = (AW1'(hi) - AW1'(lo)) > AW1'(2);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bls_pkg::S_IDLE: begin
        if (accept) begin
          unique case (kind)
            bls_pkg::KIND_POP, bls_pkg::KIND_PEEK: begin
              if (!empty) state_next = bls_pkg::S_READ;
            end
            bls_pkg::KIND_DUMP: begin
              if (!empty) state_next = bls_pkg::S_DUMP;
            end
            bls_pkg::KIND_REVERSE: begin
              if (!empty && cnt != CNT_W'(1)) state_next = bls_pkg::S_REV_WR_LO;
            end
            default: state_next = bls_pkg::S_IDLE;
          endcase
        end
      end
      bls_pkg::S_READ: begin
        if (out_free) state_next = bls_pkg::S_IDLE;
      end
      bls_pkg::S_DUMP: begin
        if (out_free && dump_last) state_next = bls_pkg::S_IDLE;
      end
      bls_pkg::S_REV_WR_LO: state_next = bls_pkg::S_REV_WR_HI;
      bls_pkg::S_REV_WR_HI: begin
        state_next = rev_more ? bls_pkg::S_REV_WR_LO : bls_pkg::S_DONE;
      end
      bls_pkg::S_DONE: begin
        if (out_free) state_next = bls_pkg::S_IDLE;
      end
      default: state_next = bls_pkg::S_IDLE;
    endcase
  end

  // outputs, memory strobes and datapath updates
  always_comb begin
    in_ready  = 1'b0;
    emit      = 1'b0;
    e_value   = '0;
    e_status  = bls_pkg::ST_OK;
    e_last    = 1'b1;
    cnt_next  = cnt;
    lo_next   = lo;
    hi_next   = hi;
    ram_ctl   = '0;
    waddr     = lo;
    wdata     = rdata_b;
    raddr_a   = lo;
    raddr_b   = hi;
    unique case (state)
      bls_pkg::S_IDLE: begin
        in_ready = out_free;
        if (accept) begin
          unique case (kind)
            bls_pkg::KIND_PUSH: begin
              emit = 1'b1;
              if (full) begin
                e_status = bls_pkg::ST_OVERFLOW;
              end else begin
                ram_ctl.wr_en = 1'b1;
                waddr         = ADDR_W'(cnt);
                wdata         = cmd.push_value;
                cnt_next      = cnt + CNT_W'(1);
              end
            end
            bls_pkg::KIND_POP, bls_pkg::KIND_PEEK: begin
              if (empty) begin
                emit     = 1'b1;
                e_status = bls_pkg::ST_EMPTY;
              end else begin
                ram_ctl.rd_en = 1'b1;
                raddr_a       = top_addr;
              end
            end
            bls_pkg::KIND_DUMP: begin
              if (empty) begin
                emit     = 1'b1;
                e_status = bls_pkg::ST_EMPTY;
              end else begin
                ram_ctl.rd_en = 1'b1;
                raddr_a       = '0;
                lo_next       = '0;
              end
            end
            bls_pkg::KIND_REVERSE: begin
              if (empty) begin
                emit     = 1'b1;
                e_status = bls_pkg::ST_EMPTY;
              end else if (cnt == CNT_W'(1)) begin
                emit = 1'b1;
              end else begin
                ram_ctl.rd_en = 1'b1;
                raddr_a       = '0;
                raddr_b       = top_addr;
                lo_next       = '0;
                hi_next       = top_addr;
              end
            end
            bls_pkg::KIND_CLEAR: begin
              emit     = 1'b1;
              cnt_next = '0;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      bls_pkg::S_READ: begin
        if (out_free) begin
          emit    = 1'b1;
          e_value = rdata_a;
          if (is_pop) cnt_next = cnt - CNT_W'(1);
        end
      end
      bls_pkg::S_DUMP: begin
        if (out_free) begin
          emit    = 1'b1;
          e_value = rdata_a;
          e_last  = dump_last;
          if (!dump_last) begin
            lo_next       = lo + ADDR_W'(1);
            ram_ctl.rd_en = 1'b1;
            raddr_a       = lo + ADDR_W'(1);
          end
        end
      end
      bls_pkg::S_REV_WR_LO: begin
        ram_ctl.wr_en = 1'b1;
        waddr         = lo;
        wdata         = rdata_b;
      end
      bls_pkg::S_REV_WR_HI: begin
        ram_ctl.wr_en = 1'b1;
        waddr         = hi;
        wdata         = rdata_a;
        lo_next       = lo + ADDR_W'(1);
        hi_next       = hi - ADDR_W'(1);
        if (rev_more) begin
          ram_ctl.rd_en = 1'b1;
          raddr_a       = lo + ADDR_W'(1);
          raddr_b       = hi - ADDR_W'(1);
        end
      end
      bls_pkg::S_DONE: begin
        emit = out_free;
      end
      default: emit = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bls_pkg::S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk pointers and command flavour
  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
    if (accept) begin
      is_pop <= (kind == bls_pkg::KIND_POP);
    end
  end

  // result payload, loaded with the count after the step
  always_ff @(posedge clk) begin
    if (emit) begin
      out_value  <= e_value;
      out_status <= e_status;
      out_cnt    <= cnt_next;
      out_last   <= e_last;
    end
  end

  assign cmd.ready    = in_ready;
  assign res.valid    = out_valid;
  assign res.value    = out_value;
  assign res.status   = out_status;
  assign res.count    = bls_pkg::COUNT_W'(out_cnt);
  assign res.is_empty = (out_cnt == '0);
  assign res.is_full  = (out_cnt == CNT_W'(DEPTH));
  assign res.last     = out_last;

endmodule

### rtl/bounded_lifo_stack.sv
// Bounded LIFO stack of DEPTH raw 32-bit words held in a synchronous memory
// with one write port and two registered read ports. Commands arrive on cmd
// (push, pop, peek, dump, reverse, clear); every command gives one result on
// res, except a dump of a non-empty stack, which gives one result per stored
// word from bottom to top with last set on the top word. Each result carries
// the count after the command and the empty and full flags. Push, clear, a
// reverse of a single word and any command that fails on a full or empty
// stack answer from the idle state; pop and peek pass through a read state
// for the memory read; dump gives one word per cycle while the result sink
// keeps up; a reverse of two or more words swaps pairs from the ends inward
// in write-low and write-high states, the single write port moving one word
// of each swapped pair per cycle. A sink holding off a full output register
// delays results. A new command is taken once the previous one has loaded its
// final result into the output register. No clearing pass follows reset.
module bounded_lifo_stack #(
  parameter int DEPTH = bls_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  bls_cmd_if.sink   cmd,
  bls_res_if.source res
);

  localparam int ADDR_W = $clog2(DEPTH);

  bls_pkg::ram_ctl_t          ram_ctl;
  logic [ADDR_W-1:0]          waddr;
  logic [bls_pkg::WORD_W-1:0] wdata;
  logic [ADDR_W-1:0]          raddr_a;
  logic [ADDR_W-1:0]          raddr_b;
  logic [bls_pkg::WORD_W-1:0] rdata_a;
  logic [bls_pkg::WORD_W-1:0] rdata_b;

  // command sequencer and output register
  bls_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .res     (res),
    .ram_ctl (ram_ctl),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // element store
  bls_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .ctl     (ram_ctl),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

endmodule

### rtl/bls_checker.sv
`include "bounded_lifo_stack_defines.svh"

module bls_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [bls_pkg::WORD_W-1:0]   res_value,
  input logic [bls_pkg::STATUS_W-1:0] res_status,
  input logic                         res_is_empty,
  input logic                         res_is_full,
  input logic                         res_last
);

  // no result straight out of reset
  `BLS_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !res_valid, "result valid after reset")

  // an overflow only ever reports a full stack, as a single zero result
  `BLS_ASSERT(a_overflow_full, clk, rst, res_valid && res_status == bls_pkg::ST_OVERFLOW |-> res_is_full && res_last && res_value == '0, "bad overflow result")

  // an empty report comes from an empty stack, as a single zero result
  `BLS_ASSERT(a_empty_flag, clk, rst, res_valid && res_status == bls_pkg::ST_EMPTY |-> res_is_empty && res_last && res_value == '0, "bad empty result")

  // a stalled result holds
  `BLS_ASSERT(a_stall_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_last), "result changed under stall")

endmodule

bind bounded_lifo_stack bls_checker u_bls_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_value    (res.value),
  .res_status   (res.status),
  .res_is_empty (res.is_empty),
  .res_is_full  (res.is_full),
  .res_last     (res.last)
);
